FILE: hdl/pd_servo_rk4_step_macros.svh
// assertion helpers for the servo integrator
`ifndef PD_SERVO_RK4_STEP_MACROS_SVH
`define PD_SERVO_RK4_STEP_MACROS_SVH
`ifndef SYNTHESIS
`define PD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define PD_ASSERT(lbl, clk, rstn, prop, msg)
`define PD_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

FILE: hdl/pd_rk4_pkg.sv
package pd_rk4_pkg;

  localparam int FracBits = 24;
  localparam int DataW    = 32;
  localparam int SumW     = 35;
  localparam int CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] RegTarget = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKp     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKd     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegInvI   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegVisc   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegStep   = 3'd5;

  localparam logic [31:0] RstTarget = 32'd16777216;
  localparam logic [31:0] RstKp     = 32'd1677721600;
  localparam logic [31:0] RstKd     = 32'd335544320;
  localparam logic [31:0] RstInvI   = 32'd8388608;
  localparam logic [31:0] RstVisc   = 32'd25165824;
  localparam logic [30:0] RstStep   = 31'd16777;

  localparam logic [31:0] MaxVal = 32'h7fff_ffff;
  localparam logic [31:0] MinVal = 32'h8000_0000;

  typedef struct packed {
    logic start;
    logic half;
  } mul_req_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } mul_rsp_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } sat_res_t;

  // 32-bit add or subtract, clamped
  function automatic sat_res_t sat_sum(logic [31:0] a, logic [31:0] b, logic sub);
    logic [32:0] s;
    sat_res_t    r;
    s = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
    r.ovf = (s[32] != s[31]);
    r.val = r.ovf ? (s[32] ? MinVal : MaxVal) : s[31:0];
    return r;
  endfunction

endpackage

FILE: hdl/pd_servo_rk4_step.sv
// one rk4 tick of a pd-controlled inertia, q8.24 fixed point
// 24 products on one shared bit-serial multiplier and two bit-serial
// divides by six per transaction; one item at a time
// reset: angle and rate clear to zero, registers take their default values
module pd_servo_rk4_step import pd_rk4_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               clear_first_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        angle_out_o,
  output logic [31:0]        rate_out_o,
  output logic               saturated_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

`include "pd_servo_rk4_step_macros.svh"

  localparam logic [4:0] SIdle = 5'd0;
  localparam logic [4:0] SErr  = 5'd1;
  localparam logic [4:0] SMkp  = 5'd2;
  localparam logic [4:0] SMkd  = 5'd3;
  localparam logic [4:0] STorq = 5'd4;
  localparam logic [4:0] SMinv = 5'd5;
  localparam logic [4:0] SMvis = 5'd6;
  localparam logic [4:0] SKr   = 5'd7;
  localparam logic [4:0] SAcc  = 5'd8;
  localparam logic [4:0] SMha  = 5'd9;
  localparam logic [4:0] SMhr  = 5'd10;
  localparam logic [4:0] SUpd  = 5'd11;
  localparam logic [4:0] SDiva = 5'd12;
  localparam logic [4:0] SDivr = 5'd13;
  localparam logic [4:0] SMfa  = 5'd14;
  localparam logic [4:0] SMfr  = 5'd15;
  localparam logic [4:0] SFin  = 5'd16;
  localparam logic [4:0] SDone = 5'd17;

  localparam logic [5:0] DivSteps = 6'(SumW);

  logic [31:0] target_q, kp_q, kd_q, invi_q, visc_q;
  logic [30:0] step_q;

  logic [4:0]  state_q;
  logic [1:0]  stage_q;
  logic [31:0] ang0_q, rate0_q, ta_q, tr_q, err_q, t1_q, t2_q, kr_q, qa_q, qr_q;
  logic [SumW-1:0] sa_q, sr_q;
  logic        sat_q, mbusy_q, dbusy_q;
  logic [SumW-1:0] div_u_q;
  logic [2:0]  div_rem_q;
  logic        div_neg_q;
  logic [5:0]  div_cnt_q;

  logic        out_valid_q, out_sat_q;
  logic [31:0] out_ang_q, out_rate_q;

  mul_req_t    mreq;
  mul_rsp_t    mrsp;
  logic [31:0] ma, mb, mres;
  logic        is_mul_st, to_t1;

  sat_res_t    err_s, diff_s, upd_a, upd_r;
  logic [31:0] h;
  logic [SumW-1:0] div_src, div_t, acc_a, acc_r;
  logic [3:0]  rem4;
  logic        w2, out_free;
  logic [31:0] div_q;

  assign h = {1'b0, step_q};

  always_comb begin
    is_mul_st = 1'b1;
    to_t1     = 1'b1;
    ma        = tr_q;
    mb        = h;
    case (state_q)
      SMkp:    begin ma = kp_q;   mb = err_q;  end
      SMkd:    begin ma = kd_q;   mb = tr_q;   to_t1 = 1'b0; end
      SMinv:   begin ma = t1_q;   mb = invi_q; end
      SMvis:   begin ma = visc_q; mb = tr_q;   to_t1 = 1'b0; end
      SMha:    begin ma = tr_q;   mb = h;      end
      SMhr:    begin ma = kr_q;   mb = h;      to_t1 = 1'b0; end
      SMfa:    begin ma = qa_q;   mb = h;      end
      SMfr:    begin ma = qr_q;   mb = h;      to_t1 = 1'b0; end
      default: is_mul_st = 1'b0;
    endcase
    mreq.start = is_mul_st && !mbusy_q;
    // half-step increments in the first two stages, full step in the third
    mreq.half  = (state_q == SMha || state_q == SMhr) && (stage_q != 2'd2);
  end

  pd_rk4_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .a_i    (ma),
    .b_i    (mb),
    .rsp_o  (mrsp),
    .res_o  (mres)
  );

  always_comb begin
    err_s  = sat_sum(target_q, ta_q, 1'b1);
    diff_s = sat_sum(t1_q, t2_q, 1'b1);
    upd_a  = sat_sum(ang0_q, t1_q, 1'b0);
    upd_r  = sat_sum(rate0_q, t2_q, 1'b0);
    w2     = (stage_q == 2'd1) || (stage_q == 2'd2);
    acc_a  = sa_q + (w2 ? {{(SumW-33){tr_q[31]}}, tr_q, 1'b0}
                        : {{(SumW-32){tr_q[31]}}, tr_q});
    acc_r  = sr_q + (w2 ? {{(SumW-33){diff_s.val[31]}}, diff_s.val, 1'b0}
                        : {{(SumW-32){diff_s.val[31]}}, diff_s.val});
    div_src = (state_q == SDiva) ? sa_q : sr_q;
    div_t   = div_src + SumW'(3);
    rem4    = {div_rem_q, div_u_q[SumW-1]};
    // floor of a negative dividend through its complement
    div_q   = div_neg_q ? ~div_u_q[31:0] : div_u_q[31:0];
    out_free = !out_valid_q || out_ready_i;
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= RstTarget;
      kp_q     <= RstKp;
      kd_q     <= RstKd;
      invi_q   <= RstInvI;
      visc_q   <= RstVisc;
      step_q   <= RstStep;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegTarget: target_q <= cfg_data_i;
        RegKp:     kp_q     <= cfg_data_i;
        RegKd:     kd_q     <= cfg_data_i;
        RegInvI:   invi_q   <= cfg_data_i;
        RegVisc:   visc_q   <= cfg_data_i;
        RegStep:   step_q   <= cfg_data_i[30:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      stage_q     <= 2'd0;
      ang0_q      <= 32'd0;
      rate0_q     <= 32'd0;
      mbusy_q     <= 1'b0;
      dbusy_q     <= 1'b0;
      div_cnt_q   <= 6'd0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i && !(state_q == SDone && out_free)) begin
        out_valid_q <= 1'b0;
      end
      if (is_mul_st) begin
        if (!mbusy_q) begin
          mbusy_q <= 1'b1;
        end else if (mrsp.done) begin
          mbusy_q <= 1'b0;
          sat_q   <= sat_q | mrsp.ovf;
          if (to_t1) begin
            t1_q <= mres;
          end else begin
            t2_q <= mres;
          end
        end
      end
      case (state_q)
        SIdle: begin
          if (in_valid_i) begin
            if (clear_first_i) begin
              ang0_q  <= 32'd0;
              rate0_q <= 32'd0;
              ta_q    <= 32'd0;
              tr_q    <= 32'd0;
            end else begin
              ta_q <= ang0_q;
              tr_q <= rate0_q;
            end
            stage_q <= 2'd0;
            sa_q    <= '0;
            sr_q    <= '0;
            sat_q   <= 1'b0;
            state_q <= SErr;
          end
        end
        SErr: begin
          err_q   <= err_s.val;
          sat_q   <= sat_q | err_s.ovf;
          state_q <= SMkp;
        end
        SMkp:  if (mbusy_q && mrsp.done) state_q <= SMkd;
        SMkd:  if (mbusy_q && mrsp.done) state_q <= STorq;
        STorq: begin
          t1_q    <= diff_s.val;
          sat_q   <= sat_q | diff_s.ovf;
          state_q <= SMinv;
        end
        SMinv: if (mbusy_q && mrsp.done) state_q <= SMvis;
        SMvis: if (mbusy_q && mrsp.done) state_q <= SKr;
        SKr: begin
          kr_q    <= diff_s.val;
          sat_q   <= sat_q | diff_s.ovf;
          state_q <= SAcc;
        end
        SAcc: begin
          sa_q <= acc_a;
          sr_q <= sr_q + (w2 ? {{(SumW-33){kr_q[31]}}, kr_q, 1'b0}
                             : {{(SumW-32){kr_q[31]}}, kr_q});
          state_q <= (stage_q == 2'd3) ? SDiva : SMha;
        end
        SMha: if (mbusy_q && mrsp.done) state_q <= SMhr;
        SMhr: if (mbusy_q && mrsp.done) state_q <= SUpd;
        SUpd: begin
          ta_q    <= upd_a.val;
          tr_q    <= upd_r.val;
          sat_q   <= sat_q | upd_a.ovf | upd_r.ovf;
          stage_q <= stage_q + 2'd1;
          state_q <= SErr;
        end
        SDiva, SDivr: begin
          if (!dbusy_q) begin
            dbusy_q   <= 1'b1;
            div_neg_q <= div_t[SumW-1];
            div_u_q   <= div_t[SumW-1] ? ~div_t : div_t;
            div_rem_q <= 3'd0;
            div_cnt_q <= 6'd0;
          end else if (div_cnt_q == DivSteps) begin
            dbusy_q <= 1'b0;
            if (state_q == SDiva) begin
              qa_q    <= div_q;
              state_q <= SDivr;
            end else begin
              qr_q    <= div_q;
              state_q <= SMfa;
            end
          end else begin
            // restoring divide by six, one quotient bit per cycle
            if (rem4 >= 4'd6) begin
              div_rem_q <= 3'(rem4 - 4'd6);
              div_u_q   <= {div_u_q[SumW-2:0], 1'b1};
            end else begin
              div_rem_q <= rem4[2:0];
              div_u_q   <= {div_u_q[SumW-2:0], 1'b0};
            end
            div_cnt_q <= div_cnt_q + 6'd1;
          end
        end
        SMfa: if (mbusy_q && mrsp.done) state_q <= SMfr;
        SMfr: if (mbusy_q && mrsp.done) state_q <= SFin;
        SFin: begin
          ang0_q  <= upd_a.val;
          rate0_q <= upd_r.val;
          sat_q   <= sat_q | upd_a.ovf | upd_r.ovf;
          state_q <= SDone;
        end
        SDone: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_ang_q   <= ang0_q;
            out_rate_q  <= rate0_q;
            out_sat_q   <= sat_q;
            state_q     <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign in_ready_o  = (state_q == SIdle);
  assign cfg_ready_o = (state_q == SIdle);
  assign out_valid_o = out_valid_q;
  assign angle_out_o = out_ang_q;
  assign rate_out_o  = out_rate_q;
  assign saturated_o = out_sat_q;

  `PD_ASSERT(a_accept_leaves_idle, clk_i, rst_ni, in_valid_i && in_ready_o |=> state_q == SErr, "accepted transaction did not start a step")
  `PD_ASSERT(a_done_loads_out, clk_i, rst_ni, state_q == SDone && out_free |=> out_valid_o && state_q == SIdle, "finished step not presented")
  `PD_ASSERT_NEVER(a_mul_done_unclaimed, clk_i, rst_ni, mrsp.done && !mbusy_q, "multiplier result with no requester")
  `PD_ASSERT_NEVER(a_div_cnt_range, clk_i, rst_ni, div_cnt_q > DivSteps, "divider ran past its last step")

endmodule

FILE: hdl/pd_rk4_mul.sv
module pd_rk4_mul import pd_rk4_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mul_req_t    req_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output mul_rsp_t    rsp_o,
  output logic [31:0] res_o
);

  localparam logic [1:0] PIdle = 2'd0;
  localparam logic [1:0] PRun  = 2'd1;
  localparam logic [1:0] PNeg  = 2'd2;
  localparam logic [1:0] PRnd  = 2'd3;

  localparam logic signed [64:0] RndFull = 65'sd1 <<< (FracBits - 1);
  localparam logic signed [64:0] RndHalf = 65'sd1 <<< FracBits;

  logic [1:0]  phase_q;
  logic [31:0] mcand_q, mplier_q, res_q;
  logic [63:0] prod_q;
  logic [4:0]  cnt_q;
  logic        neg_q, half_q, done_q, ovf_q;

  logic [32:0]        part_sum;
  logic signed [64:0] p_ext, p_rnd, p_sh;
  logic               p_ovf;

  // one multiplier bit per cycle, magnitude shift-add
  assign part_sum = {1'b0, prod_q[63:32]} + (mplier_q[0] ? {1'b0, mcand_q} : 33'd0);

  always_comb begin
    p_ext = $signed({prod_q[63], prod_q});
    p_rnd = p_ext + (half_q ? RndHalf : RndFull);
    p_sh  = half_q ? (p_rnd >>> (FracBits + 1)) : (p_rnd >>> FracBits);
    p_ovf = !((&p_sh[64:31]) || !(|p_sh[64:31]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PIdle;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (phase_q)
        PIdle: begin
          if (req_i.start) begin
            mcand_q  <= a_i[31] ? (32'd0 - a_i) : a_i;
            mplier_q <= b_i[31] ? (32'd0 - b_i) : b_i;
            neg_q    <= a_i[31] ^ b_i[31];
            half_q   <= req_i.half;
            prod_q   <= 64'd0;
            cnt_q    <= 5'd0;
            phase_q  <= PRun;
          end
        end
        PRun: begin
          prod_q   <= {part_sum, prod_q[31:1]};
          mplier_q <= {1'b0, mplier_q[31:1]};
          cnt_q    <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            phase_q <= PNeg;
          end
        end
        PNeg: begin
          if (neg_q) begin
            prod_q <= 64'd0 - prod_q;
          end
          phase_q <= PRnd;
        end
        PRnd: begin
          ovf_q   <= p_ovf;
          res_q   <= p_ovf ? (p_sh[64] ? MinVal : MaxVal) : p_sh[31:0];
          done_q  <= 1'b1;
          phase_q <= PIdle;
        end
        default: phase_q <= PIdle;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign res_o      = res_q;

endmodule

FILE: dv/pd_servo_rk4_step_tb.sv
module pd_servo_rk4_step_tb import pd_rk4_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] angle;
    logic [31:0] rate;
    logic        sat;
  } servo_res_t;

  // plant predictor plus fifo of predicted ticks
  class servo_scoreboard;
    logic signed [31:0] tgt, kp, kd, inv_i, visc;
    logic signed [31:0] hstep;
    logic signed [31:0] ang, rt;
    bit                 sat;
    servo_res_t         pending[$];
    int                 errors;

    function new();
      tgt = RstTarget; kp = RstKp; kd = RstKd; inv_i = RstInvI; visc = RstVisc;
      hstep = {1'b0, RstStep};
      ang = 0; rt = 0; errors = 0;
    endfunction

    function logic signed [31:0] clamp(logic signed [63:0] v);
      if (v > 64'sh7fffffff) begin
        sat = 1; return 32'sh7fffffff;
      end
      if (v < -64'sh80000000) begin
        sat = 1; return 32'sh80000000;
      end
      return v[31:0];
    endfunction

    function logic signed [31:0] mul_round(logic signed [31:0] a, logic signed [31:0] b,
                                           int sh);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      p = p + (64'sd1 <<< (sh - 1));
      return clamp(p >>> sh);
    endfunction

    function logic signed [31:0] add_s(logic signed [31:0] a, logic signed [31:0] b);
      return clamp(64'(a) + 64'(b));
    endfunction

    function logic signed [31:0] sub_s(logic signed [31:0] a, logic signed [31:0] b);
      return clamp(64'(a) - 64'(b));
    endfunction

    function logic signed [31:0] div_six(logic signed [63:0] s);
      logic signed [63:0] t, q;
      t = s + 3;
      if (t >= 0) q = t / 6;
      else q = -((-t + 5) / 6);
      return clamp(q);
    endfunction

    function void deriv(logic signed [31:0] a, logic signed [31:0] r,
                        output logic signed [31:0] da, output logic signed [31:0] dr);
      logic signed [31:0] err, torque;
      err = sub_s(tgt, a);
      torque = sub_s(mul_round(kp, err, FracBits), mul_round(kd, r, FracBits));
      da = r;
      dr = sub_s(mul_round(torque, inv_i, FracBits), mul_round(visc, r, FracBits));
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] d);
      case (idx)
        RegTarget: tgt = d;
        RegKp:     kp = d;
        RegKd:     kd = d;
        RegInvI:   inv_i = d;
        RegVisc:   visc = d;
        RegStep:   hstep = {1'b0, d[30:0]};
        default: ;
      endcase
    endfunction

    function void note_tick(logic clr);
      logic signed [31:0] a1, r1, a2, r2, a3, r3, a4, r4, ta, tr;
      logic signed [63:0] sa, sr;
      servo_res_t e;
      sat = 0;
      if (clr) begin
        ang = 0; rt = 0;
      end
      deriv(ang, rt, a1, r1);
      ta = add_s(ang, mul_round(a1, hstep, FracBits + 1));
      tr = add_s(rt, mul_round(r1, hstep, FracBits + 1));
      deriv(ta, tr, a2, r2);
      ta = add_s(ang, mul_round(a2, hstep, FracBits + 1));
      tr = add_s(rt, mul_round(r2, hstep, FracBits + 1));
      deriv(ta, tr, a3, r3);
      ta = add_s(ang, mul_round(a3, hstep, FracBits));
      tr = add_s(rt, mul_round(r3, hstep, FracBits));
      deriv(ta, tr, a4, r4);
      sa = 64'(a1) + 2 * 64'(a2) + 2 * 64'(a3) + 64'(a4);
      sr = 64'(r1) + 2 * 64'(r2) + 2 * 64'(r3) + 64'(r4);
      ang = add_s(ang, mul_round(div_six(sa), hstep, FracBits));
      rt = add_s(rt, mul_round(div_six(sr), hstep, FracBits));
      e.angle = ang; e.rate = rt; e.sat = sat;
      pending.push_back(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    endtask

    task check_tick(logic [31:0] a, logic [31:0] r, logic s);
      servo_res_t e;
      if (pending.size() == 0) begin
        report("unexpected result", a, 0);
        return;
      end
      e = pending.pop_front();
      if (a !== e.angle) report("angle_out", a, e.angle);
      if (r !== e.rate) report("rate_out", r, e.rate);
      if (s !== e.sat) report("saturated", s, e.sat);
    endtask
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, in_ready_o, clear_first_i = 0;
  logic out_valid_o, out_ready_i = 0;
  logic [31:0] angle_out_o, rate_out_o;
  logic saturated_o;
  logic cfg_valid_i = 0, cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  servo_scoreboard sb = new();
  bit no_idle = 0, hold_sink = 0;
  int quiet_cycles = 0;
  localparam int QuietLimit = 20000;

  always #5 clk_i = ~clk_i;

  pd_servo_rk4_step uut (.*);

  // accept and check on rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_tick(clear_first_i);
      if (out_valid_o && out_ready_i) sb.check_tick(angle_out_o, rate_out_o, saturated_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // result receiver with random stall bursts
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_sink) out_ready_i <= 0;
      else if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 0;
        n = $urandom_range(1, 13);
        repeat (n) @(negedge clk_i);
        out_ready_i <= 1;
      end else out_ready_i <= 1;
    end
  end

  task automatic send_tick(logic clr);
    @(negedge clk_i);
    in_valid_i <= 1;
    clear_first_i <= clr;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i <= 0;
    if (!no_idle && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 13)) @(negedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [31:0] d);
    @(negedge clk_i);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, d);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h0fffffff);
      3: return -$urandom_range(0, 32'h0fffffff);
      default: return $urandom;
    endcase
  endfunction

  // realistic gains near defaults, sometimes wild
  task automatic random_setup();
    write_cfg(RegTarget, $urandom_range(0, 3) == 0 ? rnd_word() :
              32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000));
    write_cfg(RegKp, $urandom_range(0, 3) == 0 ? rnd_word() : $urandom_range(0, 32'h7000_0000));
    write_cfg(RegKd, $urandom_range(0, 3) == 0 ? rnd_word() : $urandom_range(0, 32'h2000_0000));
    write_cfg(RegInvI, $urandom_range(0, 3) == 0 ? rnd_word() : $urandom_range(0, 32'h0200_0000));
    write_cfg(RegVisc, $urandom_range(0, 3) == 0 ? rnd_word() : $urandom_range(0, 32'h0400_0000));
    write_cfg(RegStep, $urandom_range(0, 3) == 0 ? rnd_word() : $urandom_range(0, 32'h0010_0000));
    if ($urandom_range(0, 1)) write_cfg(3'd6 + 3'($urandom_range(0, 1)), $urandom);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // defaults, then clear mid-run
    repeat (4) send_tick(0);
    send_tick(1);
    send_tick(0);
    drain();
    // extremes: target, kp and inv-inertia at max with kd and visc at min, then the reverse
    write_cfg(RegTarget, 32'h7fffffff);
    write_cfg(RegKp, 32'h7fffffff);
    write_cfg(RegKd, 32'h80000000);
    write_cfg(RegInvI, 32'h7fffffff);
    write_cfg(RegVisc, 32'h80000000);
    write_cfg(RegStep, 32'hffffffff);
    repeat (4) send_tick(0);
    send_tick(1);
    drain();
    write_cfg(RegTarget, 32'h80000000);
    write_cfg(RegKp, 32'h80000000);
    write_cfg(RegKd, 32'h7fffffff);
    write_cfg(RegInvI, 32'h80000000);
    write_cfg(RegVisc, 32'h7fffffff);
    write_cfg(RegStep, 32'h0);
    write_cfg(3'd7, 32'hffffffff);
    repeat (3) send_tick(1);
    send_tick(0);
    drain();

    // receiver held off while sender keeps going
    hold_sink = 1;
    fork
      repeat (5) send_tick(0);
      begin
        repeat (3000) @(posedge clk_i);
        hold_sink = 0;
      end
    join
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      random_setup();
      if (ph == 9) no_idle = 1;
      for (int i = 0; i < 52; i++) send_tick($urandom_range(0, 15) == 0);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

FILE: pd_servo_rk4_step.f
+incdir+hdl
hdl/pd_rk4_pkg.sv
hdl/pd_rk4_mul.sv
hdl/pd_servo_rk4_step.sv
dv/pd_servo_rk4_step_tb.sv
